// ===== sv/hjbp_pkg.sv =====
`default_nettype none

package hjbp_pkg;

    localparam int TABLE_SLOTS_DEF = 4096;

    // round(0.618304 * 2^32): the hash multiplier as a 32-bit fraction.
    localparam logic [31:0] HASH_MULT = 32'd2655595459;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 13'd4096;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_BUILD = 2'd1,
        FUNC_PROBE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_WALK,
        ST_CLEAR,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic        vld;
        logic [31:0] key;
        logic [31:0] value;
    } t_slot;

    typedef struct packed {
        logic               hit;
        logic               table_full;
        logic signed [31:0] build_payload;
        logic signed [31:0] probe_payload;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/hash_join_build_probe_core.sv =====
// Build and probe item: a hash state reads the home slot, then the linear-probing walk
// reads the slots in turn (one slot per cycle through the table memory port).
// Clear item: sweeps every slot of the table, one slot a cycle; other func codes read no slot.
// One item at a time: the next is taken in the cycle its result appears, unless it waits.
// After reset the block sweeps every slot of the table with the input stalled.
// Reset sets active_slots to 4096; configuration writes are taken in every cycle.
`default_nettype none

module hash_join_build_probe_core #(
    parameter int TABLE_SLOTS = hjbp_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [hjbp_pkg::CFG_W-1:0]    i_cfg_active_slots,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_func,
    input  wire logic [31:0]                   i_join_key,
    input  wire logic signed [31:0]            i_payload,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic                               o_table_full,
    output logic signed [31:0]                 o_build_payload,
    output logic signed [31:0]                 o_probe_payload
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

    hjbp_pkg::t_state  r_state, n_state;
    hjbp_pkg::t_slot   r_mem [TABLE_SLOTS];
    hjbp_pkg::t_slot   r_rd;
    hjbp_pkg::t_result r_out, r_pend, n_pend, res;

    logic [hjbp_pkg::CFG_W-1:0] r_active_slots;
    logic [1:0]                 r_func;
    logic [31:0]                r_key;
    logic signed [31:0]         r_payload;
    logic [31:0]                r_frac;
    logic [AW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       r_out_valid;

    logic [CW-1:0]    n_eff;
    logic [31:0]      act_ext;
    logic [31:0]      frac_in;
    logic [32+CW-1:0] hprod;
    logic [AW-1:0]    hidx;
    logic [CW-1:0]    cnt_inc;
    logic [CW-1:0]    idx_inc;
    logic             last;
    logic [AW-1:0]    idx_next;
    logic             in_acc;
    logic             out_free;
    logic             done;
    logic             load_out;
    logic             load_pend;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    hjbp_pkg::t_slot  mem_wdata;
    logic [AW-1:0]    rd_addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != hjbp_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Effective slot count: zero acts as one, anything above the table size is clipped.
    assign act_ext = 32'(r_active_slots);
    always_comb begin
        if (act_ext == 32'd0) begin
            n_eff = CW'(1);
        end else if (act_ext > 32'(TABLE_SLOTS)) begin
            n_eff = CW'(TABLE_SLOTS);
        end else begin
            n_eff = CW'(act_ext);
        end
    end

    assign frac_in = i_join_key * hjbp_pkg::HASH_MULT;
    assign hprod   = (32+CW)'(r_frac) * (32+CW)'(n_eff);
    assign hidx    = hprod[32 +: AW];

    assign cnt_inc  = r_cnt + CW'(1);
    assign last     = (cnt_inc == n_eff);
    assign idx_inc  = CW'(r_idx) + CW'(1);
    assign idx_next = (idx_inc == n_eff) ? '0 : idx_inc[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        res       = '0;
        done      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        rd_addr   = r_idx;

        case (r_state)
            hjbp_pkg::ST_INIT, hjbp_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + AW'(1);
                if (r_idx == LAST_SLOT) begin
                    n_idx = '0;
                    if (r_state == hjbp_pkg::ST_INIT) begin
                        n_state = hjbp_pkg::ST_IDLE;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            hjbp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_func)
                        hjbp_pkg::FUNC_CLEAR: begin
                            n_idx   = '0;
                            n_state = hjbp_pkg::ST_CLEAR;
                        end
                        hjbp_pkg::FUNC_BUILD, hjbp_pkg::FUNC_PROBE: begin
                            n_state = hjbp_pkg::ST_HASH;
                        end
                        default: begin
                            // Undefined operation: all-zero result; stays idle unless the output is stalled.
                            done = 1'b1;
                        end
                    endcase
                end
            end
            hjbp_pkg::ST_HASH: begin
                rd_addr = hidx;
                n_idx   = hidx;
                n_cnt   = '0;
                n_state = hjbp_pkg::ST_WALK;
            end
            hjbp_pkg::ST_WALK: begin
                if (r_func == hjbp_pkg::FUNC_BUILD) begin
                    if (!r_rd.vld) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{vld: 1'b1, key: r_key, value: r_payload};
                        done      = 1'b1;
                    end else if (last) begin
                        res.table_full = 1'b1;
                        done           = 1'b1;
                    end
                end else begin
                    res.probe_payload = r_payload;
                    if (!r_rd.vld) begin
                        done = 1'b1;
                    end else if (r_rd.key == r_key) begin
                        res.hit           = 1'b1;
                        res.build_payload = r_rd.value;
                        done              = 1'b1;
                    end else if (last) begin
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    // Read the next slot now so the walk checks one slot each cycle.
                    rd_addr = idx_next;
                    n_idx   = idx_next;
                    n_cnt   = cnt_inc;
                end
            end
            hjbp_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = hjbp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hjbp_pkg::ST_IDLE;
            end
        endcase

        load_out  = (done && out_free) || (r_state == hjbp_pkg::ST_HOLD && out_free);
        load_pend = done && !out_free;
        if (done) begin
            n_state = out_free ? hjbp_pkg::ST_IDLE : hjbp_pkg::ST_HOLD;
            n_pend  = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= hjbp_pkg::ST_INIT;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
            r_active_slots <= hjbp_pkg::ACTIVE_SLOTS_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_slots <= i_cfg_active_slots;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (in_acc) begin
            r_func    <= i_func;
            r_key     <= i_join_key;
            r_payload <= i_payload;
            r_frac    <= frac_in;
        end
        if (load_pend) begin
            r_pend <= n_pend;
        end
        if (load_out) begin
            r_out <= (r_state == hjbp_pkg::ST_HOLD) ? r_pend : res;
        end
    end

    // Table memory: key, payload and valid bit of each slot.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out.hit;
    assign o_table_full    = r_out.table_full;
    assign o_build_payload = r_out.build_payload;
    assign o_probe_payload = r_out.probe_payload;

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hjbp_pkg::ST_WALK) |-> (r_cnt < n_eff && CW'(r_idx) < n_eff))
        else $error("probe walk ran past the active slot count");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == hjbp_pkg::ST_WALK || r_state == hjbp_pkg::ST_CLEAR
                    || r_state == hjbp_pkg::ST_INIT))
        else $error("table written outside a walk or sweep");

    a_hash_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_func == hjbp_pkg::FUNC_BUILD || i_func == hjbp_pkg::FUNC_PROBE))
        |=> (r_state == hjbp_pkg::ST_HASH))
        else $error("build or probe item did not enter hashing");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result overwrote an item not yet taken");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_pend |=> (r_state == hjbp_pkg::ST_HOLD && r_out_valid))
        else $error("pending result without a waiting output item");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int TB_SLOTS = hjbp_pkg::TABLE_SLOTS_DEF;
    localparam logic [1:0] FUNC_UNDEF = 2'd3;

    // Expected behavior of the join table, plus the results still owed by the block.
    class join_table_model;
        bit [31:0]         key_mem [TB_SLOTS];
        bit [31:0]         val_mem [TB_SLOTS];
        bit                occupied [TB_SLOTS];
        bit [12:0]         fill;
        bit [12:0]         slots_cfg;
        hjbp_pkg::t_result pending_results [$];
        int                errors;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            fill = '0;
            slots_cfg = hjbp_pkg::ACTIVE_SLOTS_RST;
            errors = 0;
        endfunction

        function void set_slots(bit [12:0] v);
            slots_cfg = v;
        endfunction

        function int owed();
            return pending_results.size();
        endfunction

        function void take_item(bit [1:0] f, bit [31:0] key, bit [31:0] pay);
            hjbp_pkg::t_result r;
            int unsigned       n;
            int unsigned       idx;
            int unsigned       k;
            bit [31:0]         frac;
            bit [63:0]         prod;
            bit                done;
            r = '0;
            done = 1'b0;
            n = (slots_cfg == 0) ? 1 : (slots_cfg > TB_SLOTS) ? TB_SLOTS : slots_cfg;
            frac = key * hjbp_pkg::HASH_MULT;
            prod = 64'(frac) * 64'(n);
            idx = prod[63:32];
            case (f)
                hjbp_pkg::FUNC_CLEAR: begin
                    foreach (occupied[i]) occupied[i] = 1'b0;
                    fill = '0;
                end
                hjbp_pkg::FUNC_BUILD: begin
                    for (k = 0; k < n && !done; k++) begin
                        if (!occupied[idx]) begin
                            occupied[idx] = 1'b1;
                            key_mem[idx] = key;
                            val_mem[idx] = pay;
                            if (fill != 13'h1FFF) fill++;
                            done = 1'b1;
                        end else begin
                            idx = (idx + 1 == n) ? 0 : idx + 1;
                        end
                    end
                    r.table_full = !done;
                end
                hjbp_pkg::FUNC_PROBE: begin
                    r.probe_payload = pay;
                    // The walk stops at an empty slot, the first equal key, or after n slots.
                    for (k = 0; k < n && !done; k++) begin
                        if (!occupied[idx]) begin
                            done = 1'b1;
                        end else if (key_mem[idx] == key) begin
                            r.hit = 1'b1;
                            r.build_payload = val_mem[idx];
                            done = 1'b1;
                        end else begin
                            idx = (idx + 1 == n) ? 0 : idx + 1;
                        end
                    end
                end
                default: begin
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(hjbp_pkg::t_result got);
            hjbp_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $error("result item with no item outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.table_full !== want.table_full) begin
                $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
                errors++;
            end
            if (got.build_payload !== want.build_payload) begin
                $error("build_payload: expected %0d, got %0d",
                       want.build_payload, got.build_payload);
                errors++;
            end
            if (got.probe_payload !== want.probe_payload) begin
                $error("probe_payload: expected %0d, got %0d",
                       want.probe_payload, got.probe_payload);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [hjbp_pkg::CFG_W-1:0]   i_cfg_active_slots;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [1:0]                   i_func;
    logic [31:0]                  i_join_key;
    logic signed [31:0]           i_payload;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic                         o_hit;
    logic                         o_table_full;
    logic signed [31:0]           o_build_payload;
    logic signed [31:0]           o_probe_payload;

    join_table_model table_model;
    bit              tx_burst;

    hash_join_build_probe_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_active_slots (i_cfg_active_slots),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_join_key         (i_join_key),
        .i_payload          (i_payload),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_table_full       (o_table_full),
        .o_build_payload    (o_build_payload),
        .o_probe_payload    (o_probe_payload)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000_000;
        $display("FAIL");
        $finish;
    end

    // Offers one item after a random gap and waits until the block takes it.
    // Valid stays high after acceptance so that back-to-back items need no toggle.
    task automatic send_item(input logic [1:0] f, input logic [31:0] key,
                             input logic [31:0] pay);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_join_key <= key;
        i_payload  <= pay;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        table_model.take_item(f, key, pay);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (table_model.owed() != 0);
    endtask

    task automatic write_slots(input logic [hjbp_pkg::CFG_W-1:0] v);
        drain_results();
        i_cfg_valid        <= 1'b1;
        i_cfg_active_slots <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        table_model.set_slots(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic over a small key set, so builds collide and probes find them.
    task automatic run_mix(input int count, input int pool_n);
        logic [31:0] pool [$];
        logic [1:0]  f;
        logic [31:0] key;
        logic [31:0] pay;
        int          r;
        pool.push_back(32'h0000_0000);
        pool.push_back(32'hFFFF_FFFF);
        repeat (pool_n) pool.push_back($urandom);
        repeat (count) begin
            r = $urandom_range(0, 99);
            f = (r < 2)  ? hjbp_pkg::FUNC_CLEAR :
                (r < 5)  ? FUNC_UNDEF :
                (r < 52) ? hjbp_pkg::FUNC_BUILD : hjbp_pkg::FUNC_PROBE;
            key = ($urandom_range(0, 4) == 0) ? $urandom
                                              : pool[$urandom_range(0, pool.size() - 1)];
            if ($urandom_range(0, 15) == 0)
                pay = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                pay = $urandom;
            send_item(f, key, pay);
        end
    endtask

    initial begin : result_sink
        hjbp_pkg::t_result got;
        int                hold;
        int                taken;
        bit                rx_burst;
        hold = 0;
        taken = 0;
        rx_burst = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && i_out_stall === 1'b0 && o_out_valid === 1'b1) begin
                got.hit           = o_hit;
                got.table_full    = o_table_full;
                got.build_payload = o_build_payload;
                got.probe_payload = o_probe_payload;
                table_model.check_result(got);
                taken++;
                // Now and then a long hold-off lets the sender back up into the block.
                if (taken % 500 == 100)
                    hold = 300;
                else
                    hold = rx_burst ? 0 : $urandom_range(0, 9);
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                if (hold > 0) i_out_stall <= 1'b1;
            end else if (i_out_stall === 1'b1) begin
                hold--;
                if (hold <= 0) i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        table_model = new();
        tx_burst = 1'b0;
        i_rst_n            <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_active_slots <= '0;
        i_in_valid         <= 1'b0;
        i_func             <= hjbp_pkg::FUNC_CLEAR;
        i_join_key         <= '0;
        i_payload          <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full-size table: empty probe, extreme keys and payloads, duplicate keys,
        // an undefined operation, and a clear.
        send_item(hjbp_pkg::FUNC_PROBE, 32'h0000_0000, 32'h8000_0000);
        send_item(hjbp_pkg::FUNC_BUILD, 32'h0000_0000, 32'h8000_0000);
        send_item(hjbp_pkg::FUNC_BUILD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(hjbp_pkg::FUNC_PROBE, 32'h0000_0000, 32'h7FFF_FFFF);
        send_item(hjbp_pkg::FUNC_PROBE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(hjbp_pkg::FUNC_BUILD, 32'h0000_0000, 32'h0000_0005);
        send_item(hjbp_pkg::FUNC_PROBE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(FUNC_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(hjbp_pkg::FUNC_PROBE, 32'h0000_3039, 32'h1234_5678);
        send_item(hjbp_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(hjbp_pkg::FUNC_PROBE, 32'h0000_0000, 32'h0000_0001);
        run_mix(250, 48);

        // One slot: the second build overflows and a probe walks the whole table.
        write_slots(13'd1);
        send_item(hjbp_pkg::FUNC_CLEAR, 32'h0, 32'h0);
        send_item(hjbp_pkg::FUNC_BUILD, 32'hA5A5_A5A5, 32'h0000_0011);
        send_item(hjbp_pkg::FUNC_BUILD, 32'h5A5A_5A5A, 32'h0000_0022);
        send_item(hjbp_pkg::FUNC_PROBE, 32'hA5A5_A5A5, 32'h0000_0033);
        send_item(hjbp_pkg::FUNC_PROBE, 32'h5A5A_5A5A, 32'h0000_0044);
        send_item(hjbp_pkg::FUNC_BUILD, 32'hA5A5_A5A5, 32'h0000_0055);
        run_mix(60, 4);

        // Zero slots behaves as one; the table keeps its contents across the change.
        write_slots(13'd0);
        run_mix(40, 4);

        write_slots(13'd16);
        send_item(hjbp_pkg::FUNC_CLEAR, 32'h0, 32'h0);
        run_mix(160, 24);

        // Above the table size clamps to it; old entries stay in place.
        write_slots(13'h1FFF);
        run_mix(250, 64);

        write_slots(13'd4097);
        run_mix(100, 32);

        write_slots(13'd37);
        send_item(hjbp_pkg::FUNC_CLEAR, 32'h0, 32'h0);
        run_mix(200, 40);

        write_slots(13'd4096);
        run_mix(240, 64);

        drain_results();
        repeat (64) @(posedge i_clk);
        if (table_model.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
